// File: rtl/core/mic_pkg.sv
`timescale 1ns / 1ps

package mic_pkg;

    localparam int KIND_W  = 2;
    localparam int VALUE_W = 10;
    localparam int TDATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PROBE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic wr_en;
        logic sweep;
        logic emit;
    } mic_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              sweep_last;
        logic              out_busy;
    } mic_sts_t;

endpackage

// File: rtl/core/mic_datapath.sv
`timescale 1ns / 1ps

module mic_datapath #(
    parameter int VALUE_BITS = 10,
    parameter int COUNT_BITS = 11
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mic_pkg::mic_cmd_t         cmd,
    output mic_pkg::mic_sts_t         sts,
    input  logic [mic_pkg::KIND_W-1:0]  in_kind,
    input  logic [mic_pkg::VALUE_W-1:0] in_value,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [mic_pkg::TDATA_W-1:0] m_tdata,
    output logic                      m_tuser
);
    import mic_pkg::*;

    localparam int DEPTH = 1 << VALUE_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] count_mem [DEPTH];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [VALUE_BITS-1:0] idx_reg;
    logic [VALUE_BITS-1:0] sweep_reg;
    logic [VALUE_BITS-1:0] sweep_next;
    logic [VALUE_BITS-1:0] wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS-1:0] new_count;
    logic                  hit;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [VALUE_W-1:0]    m_value_reg;
    logic                  m_matched_reg;

    always_comb begin
        hit = (rdata_reg != '0);
        case (kind_reg)
            KIND_LOAD: begin
                new_count = (rdata_reg == COUNT_MAX) ? rdata_reg
                                                     : rdata_reg + 1'b1;
            end
            KIND_PROBE: begin
                new_count = hit ? rdata_reg - 1'b1 : rdata_reg;
            end
            default: begin
                new_count = rdata_reg;
            end
        endcase
        wr_addr    = cmd.sweep ? sweep_reg : idx_reg;
        wr_data    = cmd.sweep ? '0 : new_count;
        sweep_next = cmd.sweep ? sweep_reg + 1'b1 : sweep_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= count_mem[VALUE_BITS'(in_value)];
        end
        if (cmd.wr_en) begin
            count_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            sweep_reg    <= sweep_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= in_kind;
            idx_reg  <= VALUE_BITS'(in_value);
        end
        if (cmd.emit) begin
            m_value_reg   <= VALUE_W'(idx_reg);
            m_matched_reg <= hit;
        end
    end

    assign sts.kind       = kind_reg;
    assign sts.sweep_last = (sweep_reg == {VALUE_BITS{1'b1}});
    assign sts.out_busy   = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_value_reg);
    assign m_tuser  = m_matched_reg;

endmodule

// File: rtl/core/mic_ctrl.sv
`timescale 1ns / 1ps

module mic_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mic_pkg::KIND_W-1:0] in_kind,
    input  mic_pkg::mic_sts_t          sts,
    output mic_pkg::mic_cmd_t          cmd
);
    import mic_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;
    logic   accept;

    assign accept = s_tvalid && s_tready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.wr_en = 1'b1;
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    unique case (in_kind) inside
                        KIND_LOAD, KIND_PROBE: begin
                            cmd.rd_en  = 1'b1;
                            state_next = ST_EXEC;
                        end
                        KIND_CLEAR: begin
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EXEC: begin
                if (!(sts.kind == KIND_PROBE && sts.out_busy)) begin
                    cmd.wr_en  = 1'b1;
                    cmd.emit   = (sts.kind == KIND_PROBE);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

endmodule

// File: rtl/core/multiset_intersection_counter.sv
`timescale 1ns / 1ps
// Channel  Direction  tdata                     tuser
// s_       in         [9:0] value               [1:0] kind
// m_       out        [9:0] value_res           [0]   matched
//
// Load and probe each do a registered table read, then the write-back.
// Clear sweeps the table one entry a cycle; an unused kind writes no table entry.
// After reset the same sweep runs before s_tready rises.
// A probe waits in its write-back cycle while a previous result is still unaccepted.
module multiset_intersection_counter #(
    parameter int VALUE_BITS = 10,
    parameter int COUNT_BITS = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mic_pkg::TDATA_W-1:0] s_tdata,  // [9:0] value
    input  logic [mic_pkg::KIND_W-1:0]  s_tuser,  // [1:0] kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mic_pkg::TDATA_W-1:0] m_tdata,  // [9:0] value_res
    output logic                        m_tuser   // [0] matched
);
    import mic_pkg::*;

    mic_cmd_t cmd;
    mic_sts_t sts;

    mic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_kind  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    mic_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_kind  (s_tuser),
        .in_value (s_tdata[VALUE_W-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: bench/multiset_intersection_checker.sv
`timescale 1ns / 1ps

module multiset_intersection_checker #(
    parameter int VALUE_BITS = 10,
    parameter int COUNT_BITS = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [mic_pkg::TDATA_W-1:0] s_tdata,
    input  logic [mic_pkg::KIND_W-1:0]  s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [mic_pkg::TDATA_W-1:0] m_tdata,
    input  logic                        m_tuser,
    output int                          failures,
    output int                          pending,
    output int                          results_checked,
    output int                          matches_seen
);
    import mic_pkg::*;

    localparam int TABLE_DEPTH = 1 << VALUE_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [VALUE_W-1:0] value_res;
        logic               matched;
    } probe_result_t;

    logic [COUNT_BITS-1:0] value_counts [TABLE_DEPTH];
    probe_result_t         expected_results [$];

    function automatic void apply_request(input logic [KIND_W-1:0] kind,
                                          input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] idx;
        probe_result_t      res;
        idx = value & VALUE_W'(TABLE_DEPTH - 1);
        case (kind)
            KIND_LOAD: begin
                if (value_counts[idx] != COUNT_MAX)
                    value_counts[idx] = value_counts[idx] + 1'b1;
            end
            KIND_PROBE: begin
                res.value_res = idx;
                res.matched   = (value_counts[idx] != '0);
                if (res.matched)
                    value_counts[idx] = value_counts[idx] - 1'b1;
                expected_results.insert(expected_results.size(), res);
            end
            KIND_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    value_counts[i] = '0;
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        probe_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                value_counts[i] = '0;
            expected_results.delete();
            failures        = 0;
            results_checked = 0;
            matches_seen    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (m_tuser)
                    matches_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: value_res %0d, matched %0b",
                           m_tdata[VALUE_W-1:0], m_tuser);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[VALUE_W-1:0] != want.value_res) begin
                        $error("value_res: expected %0d, actual %0d",
                               want.value_res, m_tdata[VALUE_W-1:0]);
                        failures++;
                    end
                    if (m_tuser != want.matched) begin
                        $error("matched: expected %0b, actual %0b",
                               want.matched, m_tuser);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata[VALUE_W-1:0]);
        end
        pending = expected_results.size();
    end

endmodule

// File: bench/multiset_intersection_counter_test.sv
`timescale 1ns / 1ps

module multiset_intersection_counter_test;
    import mic_pkg::*;

    localparam int VALUE_BITS     = 10;
    localparam int COUNT_BITS     = 11;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 700;
    localparam int PHASES         = 4;
    localparam int POOL_SIZE      = 16;

    localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0] VALUE_MIN   = '0;
    localparam logic [VALUE_W-1:0] VALUE_MAX   = '1;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]  s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;

    int failures;
    int pending;
    int results_checked;
    int matches_seen;
    int stall_cycles;
    int kind_count [4];

    logic               tx_idle;
    logic               rx_idle;
    logic               hold_req;
    logic               hold_done;
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    multiset_intersection_counter #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    multiset_intersection_checker #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .failures        (failures),
        .pending         (pending),
        .results_checked (results_checked),
        .matches_seen    (matches_seen)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else if (rx_idle && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(negedge aclk);
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [VALUE_W-1:0] value);
        if (tx_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = TDATA_W'(value);
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        kind_count[kind]++;
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic send_random_request();
        int                 r;
        logic [VALUE_W-1:0] v;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            v = VALUE_W'($urandom_range(0, 1023));
        else
            v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 3)
            send_request(KIND_CLEAR, VALUE_W'($urandom_range(0, 1023)));
        else if (r < 5)
            send_request(KIND_UNUSED, VALUE_W'($urandom_range(0, 1023)));
        else if (r < 52)
            send_request(KIND_LOAD, v);
        else
            send_request(KIND_PROBE, v);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_LOAD;
        tx_idle  = 1'b1;
        rx_idle  = 1'b1;
        hold_req = 1'b0;
        for (int k = 0; k < 4; k++)
            kind_count[k] = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // miss on empty table, extremes, back-to-back hits on one value
        send_request(KIND_PROBE, VALUE_MIN);
        send_request(KIND_LOAD, VALUE_MIN);
        send_request(KIND_LOAD, VALUE_MAX);
        send_request(KIND_LOAD, VALUE_MAX);
        send_request(KIND_PROBE, VALUE_MAX);
        send_request(KIND_PROBE, VALUE_MAX);
        send_request(KIND_PROBE, VALUE_MAX);
        send_request(KIND_PROBE, VALUE_MIN);
        send_request(KIND_PROBE, VALUE_MIN);
        send_request(KIND_LOAD, 10'h200);
        send_request(KIND_UNUSED, 10'h200);
        send_request(KIND_PROBE, 10'h200);
        send_request(KIND_UNUSED, VALUE_MAX);
        send_request(KIND_LOAD, 10'h005);
        send_request(KIND_LOAD, 10'h005);
        send_request(KIND_CLEAR, VALUE_MAX);
        send_request(KIND_PROBE, 10'h005);
        send_request(KIND_LOAD, 10'h2aa);
        send_request(KIND_LOAD, 10'h155);
        send_request(KIND_PROBE, 10'h155);
        send_request(KIND_PROBE, 10'h2aa);
        send_request(KIND_LOAD, 10'h007);
        send_request(KIND_PROBE, 10'h007);
        send_request(KIND_PROBE, 10'h007);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            value_pool[0] = VALUE_MIN;
            value_pool[1] = VALUE_MAX;
            for (int i = 2; i < POOL_SIZE; i++)
                value_pool[i] = VALUE_W'($urandom_range(0, 1023));
            if (ph == 1)
                hold_req = 1'b1;
            if (ph == PHASES - 1) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
                if (ph == 2 && i == RANDOM_ITEMS / (2 * PHASES))
                    drain_results();
                send_random_request();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("Covered %0d requests: %0d loads, %0d probes, %0d clears, %0d unused kind",
                 kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
                 kind_count[KIND_LOAD], kind_count[KIND_PROBE], kind_count[KIND_CLEAR],
                 kind_count[KIND_UNUSED]);
        $display("Checked %0d results (%0d matches), incl. output hold-off and drain",
                 results_checked, matches_seen);
        if (failures == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: multiset_intersection_counter.f
rtl/core/mic_pkg.sv
rtl/core/mic_datapath.sv
rtl/core/mic_ctrl.sv
rtl/core/multiset_intersection_counter.sv
bench/multiset_intersection_checker.sv
bench/multiset_intersection_counter_test.sv
